FILE: rtl/core/assert_macros.svh
// Assertion helpers; every user has clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off during reset.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off during reset.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/rgbconv_pkg.sv
package rgbconv_pkg;

  localparam int MAX_WIDTH   = 2048;
  localparam int MAX_HEIGHT  = 4096;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int WIDTH_W     = 12;
  localparam int HEIGHT_W    = 13;
  localparam int POS_W       = 24;
  localparam int PIX_W       = 24;
  localparam int CH_W        = 8;
  localparam int KROW_W      = 48;
  localparam int COEF_W      = 16;
  localparam int FRAC_BITS   = 12;
  localparam int PROD_W      = CH_W + 1 + COEF_W;
  localparam int RSUM_W      = PROD_W + 2;
  localparam int SUM_W       = RSUM_W + 2;
  localparam int CFG_INDEX_W = 3;
  localparam int DIV_CNT_W   = $clog2(POS_W + 1);

  typedef logic [PIX_W-1:0] pix_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_KERNEL_TOP    = 3'd0,
    CFG_KERNEL_MIDDLE = 3'd1,
    CFG_KERNEL_BOTTOM = 3'd2,
    CFG_IMAGE_WIDTH   = 3'd3,
    CFG_IMAGE_HEIGHT  = 3'd4
  } cfg_index_t;

  localparam logic [KROW_W-1:0]   KROW_TOP_RST    = 48'h0000_0000_0000;
  localparam logic [KROW_W-1:0]   KROW_MIDDLE_RST = 48'h0000_1000_0000;
  localparam logic [KROW_W-1:0]   KROW_BOTTOM_RST = 48'h0000_0000_0000;
  localparam logic [WIDTH_W-1:0]  WIDTH_RST       = WIDTH_W'(MAX_WIDTH);
  localparam logic [HEIGHT_W-1:0] HEIGHT_RST      = HEIGHT_W'(MAX_HEIGHT);

  typedef struct packed {
    logic [KROW_W-1:0] top;
    logic [KROW_W-1:0] middle;
    logic [KROW_W-1:0] bottom;
  } kernel_t;

  // Clamped frame size, both at least 1.
  typedef struct packed {
    logic [WIDTH_W-1:0]  width;
    logic [HEIGHT_W-1:0] height;
  } frame_cfg_t;

  // Raster position of the next input pixel.
  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [POS_W-1:0] row;
  } pos_t;

  // Per-result tap masks, index 0 = top / left.
  typedef struct packed {
    logic       produce;
    logic [2:0] row_ok;
    logic [2:0] col_ok;
    logic       last;
  } tap_ctl_t;

  // Nine window pixels, index row*3 + col; row 0 is the oldest line.
  typedef logic [8:0][PIX_W-1:0] window_t;

endpackage

FILE: rtl/core/rgbconv_ctrl.sv
module rgbconv_ctrl (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [rgbconv_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [rgbconv_pkg::KROW_W-1:0]       cfg_data,
  input  logic                                 accept,
  output rgbconv_pkg::kernel_t                 kernel,
  output rgbconv_pkg::frame_cfg_t              frame,
  output rgbconv_pkg::pos_t                    pos,
  output logic                                 busy
);

  logic [rgbconv_pkg::KROW_W-1:0]    ktop_r, kmid_r, kbot_r;
  logic [rgbconv_pkg::WIDTH_W-1:0]   width_r;
  logic [rgbconv_pkg::HEIGHT_W-1:0]  height_r;
  logic [rgbconv_pkg::POS_W-1:0]     p_r, p_nxt;
  logic [rgbconv_pkg::COL_W-1:0]     col_r, col_nxt;
  logic [rgbconv_pkg::POS_W-1:0]     row_r, row_nxt;
  logic [rgbconv_pkg::DIV_CNT_W-1:0] div_cnt_r;
  logic [rgbconv_pkg::WIDTH_W-1:0]   div_rem_r;
  logic [rgbconv_pkg::POS_W-1:0]     div_quot_r;
  logic [rgbconv_pkg::WIDTH_W:0]     rem_sh, rem_sub;
  logic [rgbconv_pkg::WIDTH_W-1:0]   rem_nxt;
  logic [rgbconv_pkg::POS_W-1:0]     quot_nxt;
  logic                              cfg_wr;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign kernel    = '{top: ktop_r, middle: kmid_r, bottom: kbot_r};
  assign pos       = '{col: col_r, row: row_r};
  assign busy      = div_cnt_r != '0;

  // 0 -> 1, oversize -> max
  always_comb begin
    frame.width = width_r;
    if (width_r == '0) begin
      frame.width = rgbconv_pkg::WIDTH_W'(1);
    end else if (width_r > rgbconv_pkg::WIDTH_W'(rgbconv_pkg::MAX_WIDTH)) begin
      frame.width = rgbconv_pkg::WIDTH_W'(rgbconv_pkg::MAX_WIDTH);
    end
    frame.height = height_r;
    if (height_r == '0) begin
      frame.height = rgbconv_pkg::HEIGHT_W'(1);
    end else if (height_r > rgbconv_pkg::HEIGHT_W'(rgbconv_pkg::MAX_HEIGHT)) begin
      frame.height = rgbconv_pkg::HEIGHT_W'(rgbconv_pkg::MAX_HEIGHT);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ktop_r   <= rgbconv_pkg::KROW_TOP_RST;
      kmid_r   <= rgbconv_pkg::KROW_MIDDLE_RST;
      kbot_r   <= rgbconv_pkg::KROW_BOTTOM_RST;
      width_r  <= rgbconv_pkg::WIDTH_RST;
      height_r <= rgbconv_pkg::HEIGHT_RST;
    end else if (cfg_wr) begin
      case (cfg_index)
        rgbconv_pkg::CFG_KERNEL_TOP:    ktop_r   <= cfg_data;
        rgbconv_pkg::CFG_KERNEL_MIDDLE: kmid_r   <= cfg_data;
        rgbconv_pkg::CFG_KERNEL_BOTTOM: kbot_r   <= cfg_data;
        rgbconv_pkg::CFG_IMAGE_WIDTH:   width_r  <= cfg_data[rgbconv_pkg::WIDTH_W-1:0];
        rgbconv_pkg::CFG_IMAGE_HEIGHT:  height_r <= cfg_data[rgbconv_pkg::HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // position advance; wrap once row reaches height+1
  always_comb begin
    p_nxt   = p_r + rgbconv_pkg::POS_W'(1);
    col_nxt = col_r + rgbconv_pkg::COL_W'(1);
    row_nxt = row_r;
    if (row_r >= rgbconv_pkg::POS_W'(frame.height) + rgbconv_pkg::POS_W'(1)) begin
      p_nxt   = '0;
      col_nxt = '0;
      row_nxt = '0;
    end else if (rgbconv_pkg::WIDTH_W'(col_r) == frame.width - rgbconv_pkg::WIDTH_W'(1)) begin
      col_nxt = '0;
      row_nxt = row_r + rgbconv_pkg::POS_W'(1);
    end
  end

  // restoring divide step: p / width -> row, col
  always_comb begin
    rem_sh   = {div_rem_r, div_quot_r[rgbconv_pkg::POS_W-1]};
    rem_sub  = rem_sh - {1'b0, frame.width};
    rem_nxt  = rem_sh[rgbconv_pkg::WIDTH_W-1:0];
    quot_nxt = {div_quot_r[rgbconv_pkg::POS_W-2:0], 1'b0};
    if (rem_sh >= {1'b0, frame.width}) begin
      rem_nxt     = rem_sub[rgbconv_pkg::WIDTH_W-1:0];
      quot_nxt[0] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_r       <= '0;
      col_r     <= '0;
      row_r     <= '0;
      div_cnt_r <= '0;
    end else begin
      if (cfg_wr && cfg_index == rgbconv_pkg::CFG_IMAGE_WIDTH) begin
        div_cnt_r <= rgbconv_pkg::DIV_CNT_W'(rgbconv_pkg::POS_W);
      end else if (busy) begin
        div_cnt_r <= div_cnt_r - rgbconv_pkg::DIV_CNT_W'(1);
        if (div_cnt_r == rgbconv_pkg::DIV_CNT_W'(1)) begin
          col_r <= rem_nxt[rgbconv_pkg::COL_W-1:0];
          row_r <= quot_nxt;
        end
      end
      if (accept) begin
        p_r   <= p_nxt;
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cfg_wr && cfg_index == rgbconv_pkg::CFG_IMAGE_WIDTH) begin
      div_rem_r  <= '0;
      div_quot_r <= p_r;
    end else if (busy) begin
      div_rem_r  <= rem_nxt;
      div_quot_r <= quot_nxt;
    end
  end

endmodule

FILE: rtl/core/rgbconv_lines.sv
module rgbconv_lines (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    adv,
  input  logic                    accept,
  input  rgbconv_pkg::pix_t       in_pixel,
  input  rgbconv_pkg::pos_t       pos,
  input  rgbconv_pkg::frame_cfg_t frame,
  output rgbconv_pkg::window_t    win,
  output rgbconv_pkg::tap_ctl_t   ctl
);

  rgbconv_pkg::pix_t prev_mem  [rgbconv_pkg::MAX_WIDTH];
  rgbconv_pkg::pix_t older_mem [rgbconv_pkg::MAX_WIDTH];

  logic                              s1_valid_r;
  rgbconv_pkg::pix_t                 s1_pix_r;
  logic [rgbconv_pkg::COL_W-1:0]     s1_col_r;
  logic [rgbconv_pkg::POS_W-1:0]     s1_row_r;
  rgbconv_pkg::pix_t                 prev_rd_r, older_rd_r;
  logic                              fwd_r;
  rgbconv_pkg::pix_t                 fwd_prev_r, fwd_older_r;
  rgbconv_pkg::pix_t                 s1_prev, s1_older;
  rgbconv_pkg::tap_ctl_t             s1_ctl;
  rgbconv_pkg::window_t              win_r, win_nxt;
  rgbconv_pkg::tap_ctl_t             ctl_r;

  // same column written and read at one edge (width 1): bypass the store
  assign s1_prev  = fwd_r ? fwd_prev_r  : prev_rd_r;
  assign s1_older = fwd_r ? fwd_older_r : older_rd_r;

  always_ff @(posedge clk) begin
    if (accept) begin
      prev_rd_r  <= prev_mem[pos.col];
      older_rd_r <= older_mem[pos.col];
    end
    if (adv && s1_valid_r) begin
      prev_mem[s1_col_r]  <= s1_pix_r;
      older_mem[s1_col_r] <= s1_prev;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix_r    <= in_pixel;
      s1_col_r    <= pos.col;
      s1_row_r    <= pos.row;
      fwd_prev_r  <= s1_pix_r;
      fwd_older_r <= s1_prev;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      fwd_r      <= 1'b0;
    end else begin
      if (adv) begin
        s1_valid_r <= accept;
      end
      if (accept) begin
        fwd_r <= s1_valid_r && (s1_col_r == pos.col);
      end
    end
  end

  // result belongs to the pixel one line plus one earlier
  always_comb begin
    logic [rgbconv_pkg::POS_W-1:0] r;
    logic [rgbconv_pkg::COL_W-1:0] c;
    logic [rgbconv_pkg::COL_W-1:0] w_m1;
    logic [rgbconv_pkg::POS_W-1:0] h_ext;
    logic                          started;
    w_m1  = rgbconv_pkg::COL_W'(frame.width - rgbconv_pkg::WIDTH_W'(1));
    h_ext = rgbconv_pkg::POS_W'(frame.height);
    if (s1_col_r == '0) begin
      r = s1_row_r - rgbconv_pkg::POS_W'(2);
      c = w_m1;
    end else begin
      r = s1_row_r - rgbconv_pkg::POS_W'(1);
      c = s1_col_r - rgbconv_pkg::COL_W'(1);
    end
    started = (s1_row_r >= rgbconv_pkg::POS_W'(2)) ||
              (s1_row_r == rgbconv_pkg::POS_W'(1) && s1_col_r != '0);
    s1_ctl.produce   = started && (r < h_ext);
    s1_ctl.row_ok[0] = r != '0;
    s1_ctl.row_ok[1] = 1'b1;
    s1_ctl.row_ok[2] = r < h_ext - rgbconv_pkg::POS_W'(1);
    s1_ctl.col_ok[0] = c != '0;
    s1_ctl.col_ok[1] = 1'b1;
    s1_ctl.col_ok[2] = c < w_m1;
    s1_ctl.last      = (r == h_ext - rgbconv_pkg::POS_W'(1)) && (c == w_m1);
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      win_nxt[i*3]   = win_r[i*3+1];
      win_nxt[i*3+1] = win_r[i*3+2];
    end
    win_nxt[2] = s1_older;
    win_nxt[5] = s1_prev;
    win_nxt[8] = s1_pix_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
      ctl_r <= '0;
    end else if (adv) begin
      ctl_r <= s1_valid_r ? s1_ctl : '0;
      if (s1_valid_r) begin
        win_r <= win_nxt;
      end
    end
  end

  assign win = win_r;
  assign ctl = ctl_r;

endmodule

FILE: rtl/core/rgbconv_mac.sv
module rgbconv_mac (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             adv,
  input  rgbconv_pkg::window_t             win,
  input  rgbconv_pkg::tap_ctl_t            ctl,
  input  rgbconv_pkg::kernel_t             kernel,
  output logic                             out_valid,
  output logic [rgbconv_pkg::CH_W-1:0]     out_red,
  output logic [rgbconv_pkg::CH_W-1:0]     out_green,
  output logic [rgbconv_pkg::CH_W-1:0]     out_blue,
  output logic                             out_frame_last
);

  logic [rgbconv_pkg::KROW_W-1:0]      krow [3];
  logic signed [rgbconv_pkg::PROD_W-1:0] prod_nxt [3][9];
  logic signed [rgbconv_pkg::PROD_W-1:0] prod_r   [3][9];
  logic signed [rgbconv_pkg::RSUM_W-1:0] rsum_nxt [3][3];
  logic signed [rgbconv_pkg::RSUM_W-1:0] rsum_r   [3][3];
  logic [rgbconv_pkg::CH_W-1:0]        pix_nxt  [3];
  logic [rgbconv_pkg::CH_W-1:0]        pix_r    [3];
  logic                                p_valid_r, p_last_r;
  logic                                r_valid_r, r_last_r;
  logic                                out_valid_r, out_last_r;

  // negative -> 0, else round half up at the Q.12 point, then saturate
  function automatic logic [rgbconv_pkg::CH_W-1:0] round_clamp(
    input logic signed [rgbconv_pkg::SUM_W-1:0] sum
  );
    logic [rgbconv_pkg::SUM_W-1:0] t;
    logic [rgbconv_pkg::SUM_W-rgbconv_pkg::FRAC_BITS-1:0] v;
    logic [rgbconv_pkg::CH_W-1:0] res;
    t = sum + rgbconv_pkg::SUM_W'(1 << (rgbconv_pkg::FRAC_BITS - 1));
    v = t[rgbconv_pkg::SUM_W-1:rgbconv_pkg::FRAC_BITS];
    if (sum[rgbconv_pkg::SUM_W-1]) begin
      res = '0;
    end else if (v > (rgbconv_pkg::SUM_W-rgbconv_pkg::FRAC_BITS)'(255)) begin
      res = '1;
    end else begin
      res = v[rgbconv_pkg::CH_W-1:0];
    end
    return res;
  endfunction

  assign krow[0] = kernel.top;
  assign krow[1] = kernel.middle;
  assign krow[2] = kernel.bottom;

  // 27 independent multiplies; masked taps contribute zero
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          if (ctl.row_ok[i] && ctl.col_ok[j]) begin
            prod_nxt[ch][i*3+j] =
              $signed({1'b0, win[i*3+j][rgbconv_pkg::PIX_W-1-rgbconv_pkg::CH_W*ch -:
                                        rgbconv_pkg::CH_W]}) *
              $signed(krow[i][rgbconv_pkg::COEF_W*j +: rgbconv_pkg::COEF_W]);
          end else begin
            prod_nxt[ch][i*3+j] = '0;
          end
        end
      end
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      for (int i = 0; i < 3; i++) begin
        rsum_nxt[ch][i] = rgbconv_pkg::RSUM_W'(prod_r[ch][i*3]) +
                          rgbconv_pkg::RSUM_W'(prod_r[ch][i*3+1]) +
                          rgbconv_pkg::RSUM_W'(prod_r[ch][i*3+2]);
      end
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      pix_nxt[ch] = round_clamp(rgbconv_pkg::SUM_W'(rsum_r[ch][0]) +
                                rgbconv_pkg::SUM_W'(rsum_r[ch][1]) +
                                rgbconv_pkg::SUM_W'(rsum_r[ch][2]));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r     <= prod_nxt;
      rsum_r     <= rsum_nxt;
      pix_r      <= pix_nxt;
      p_last_r   <= ctl.last;
      r_last_r   <= p_last_r;
      out_last_r <= r_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r   <= 1'b0;
      r_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      p_valid_r   <= ctl.produce;
      r_valid_r   <= p_valid_r;
      out_valid_r <= r_valid_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_red        = pix_r[0];
  assign out_green      = pix_r[1];
  assign out_blue       = pix_r[2];
  assign out_frame_last = out_last_r;

endmodule

FILE: rtl/core/rgb_convolution_3x3_core.sv
// 3x3 convolution filter for an RGB raster stream. One pixel is taken per
// clock while in_stall is low; the red, green and blue planes are each
// filtered with the same signed Q4.12 kernel, neighbours outside the image
// count as zero, and each channel is rounded half up and clamped to 0..255.
// A result belongs to the pixel taken one image line plus one pixel
// earlier, so after a frame's last pixel feed image_width+1 transactions
// with in_drain set to flush the tail; out_frame_last marks the final
// pixel of the frame. A taken transaction's result (if any) moves through
// the line-store read, window, multiply, row sums, final sum and clamp
// stages to the output register. Throughput is one transaction per clock
// while not stalled, set by the two line stores (MAX_WIDTH x 24 bits each,
// one read and one write per clock). A write to image_width holds in_stall
// high while a serial divider re-derives the raster position from the
// pixel count; other writes act at once. Program registers only while idle.
`include "assert_macros.svh"

module rgb_convolution_3x3_core (
  input  logic                                clk,
  input  logic                                rst_n,
  // pixel input
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [rgbconv_pkg::CH_W-1:0]        in_red,
  input  logic [rgbconv_pkg::CH_W-1:0]        in_green,
  input  logic [rgbconv_pkg::CH_W-1:0]        in_blue,
  input  logic                                in_drain,
  // filtered output
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [rgbconv_pkg::CH_W-1:0]        out_red,
  output logic [rgbconv_pkg::CH_W-1:0]        out_green,
  output logic [rgbconv_pkg::CH_W-1:0]        out_blue,
  output logic                                out_frame_last,
  // register writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rgbconv_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [rgbconv_pkg::KROW_W-1:0]      cfg_data
);

  logic                    adv;      // whole pipeline moves this clock
  logic                    in_acc;
  logic                    busy;
  logic                    col_in_range;
  rgbconv_pkg::pix_t       in_pixel;
  rgbconv_pkg::kernel_t    kernel;
  rgbconv_pkg::frame_cfg_t frame;
  rgbconv_pkg::pos_t       pos;
  rgbconv_pkg::window_t    win;
  rgbconv_pkg::tap_ctl_t   ctl;

  // pipeline freezes only while a finished result waits downstream
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv || busy;
  assign in_acc   = in_valid && !in_stall;

  // drain transactions push zeros through the line stores
  assign in_pixel = in_drain ? '0 : {in_red, in_green, in_blue};

  rgbconv_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (in_acc),
    .kernel    (kernel),
    .frame     (frame),
    .pos       (pos),
    .busy      (busy)
  );

  rgbconv_lines u_lines (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .accept   (in_acc),
    .in_pixel (in_pixel),
    .pos      (pos),
    .frame    (frame),
    .win      (win),
    .ctl      (ctl)
  );

  rgbconv_mac u_mac (
    .clk            (clk),
    .rst_n          (rst_n),
    .adv            (adv),
    .win            (win),
    .ctl            (ctl),
    .kernel         (kernel),
    .out_valid      (out_valid),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue),
    .out_frame_last (out_frame_last)
  );

  assign col_in_range = {1'b0, pos.col} < frame.width;

  // a width change must block input until the position is rebuilt
  `ASSERT_NEXT(a_width_wr_stalls, cfg_valid && cfg_ready && cfg_index == rgbconv_pkg::CFG_IMAGE_WIDTH, in_stall, "input taken during position rebuild")
  // accepted pixels always land inside the current line
  `ASSERT_IMPLIES(a_col_in_line, in_acc, col_in_range, "column beyond image width")

endmodule
